// ===== sv/spwm_generator_with_step_regulators_macros.svh =====
// ----------------------------------------------------------------------------
// SPWM generator macros
// Assertion shorthands used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef SPWM_GENERATOR_WITH_STEP_REGULATORS_MACROS_SVH
`define SPWM_GENERATOR_WITH_STEP_REGULATORS_MACROS_SVH

// clocked property, masked while reset is held
`define SPWMSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked property that is also checked during reset
`define SPWMSR_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/spwmsr_pkg.sv =====
// ----------------------------------------------------------------------------
// SPWM generator package
// Types, constants, sine half-wave table, sine entry and regulator step functions.
// ----------------------------------------------------------------------------
package spwmsr_pkg;

	localparam int HALF_WAVE_LEN = 225;

	localparam logic [9:0] HALF_WAVE [HALF_WAVE_LEN] = '{
		10'd6, 10'd17, 10'd28, 10'd39, 10'd50, 10'd61, 10'd72, 10'd83, 10'd94, 10'd106,
		10'd117, 10'd128, 10'd139, 10'd150, 10'd160, 10'd171, 10'd182, 10'd193, 10'd204,
		10'd215, 10'd225, 10'd236, 10'd247, 10'd257, 10'd268, 10'd278, 10'd289, 10'd299,
		10'd309, 10'd319, 10'd330, 10'd340, 10'd350, 10'd360, 10'd370, 10'd380, 10'd389,
		10'd399, 10'd409, 10'd418, 10'd428, 10'd437, 10'd446, 10'd455, 10'd465, 10'd474,
		10'd482, 10'd491, 10'd500, 10'd509, 10'd517, 10'd526, 10'd534, 10'd542, 10'd550,
		10'd558, 10'd566, 10'd574, 10'd582, 10'd589, 10'd597, 10'd604, 10'd611, 10'd618,
		10'd625, 10'd632, 10'd639, 10'd646, 10'd652, 10'd658, 10'd665, 10'd671, 10'd677,
		10'd683, 10'd688, 10'd694, 10'd699, 10'd705, 10'd710, 10'd715, 10'd720, 10'd724,
		10'd729, 10'd733, 10'd738, 10'd742, 10'd746, 10'd750, 10'd754, 10'd757, 10'd761,
		10'd764, 10'd767, 10'd770, 10'd773, 10'd776, 10'd778, 10'd781, 10'd783, 10'd785,
		10'd787, 10'd789, 10'd790, 10'd792, 10'd793, 10'd794, 10'd795, 10'd796, 10'd797,
		10'd797, 10'd798, 10'd798, 10'd798, 10'd798, 10'd798, 10'd797, 10'd797, 10'd796,
		10'd795, 10'd794, 10'd793, 10'd792, 10'd790, 10'd789, 10'd787, 10'd785, 10'd783,
		10'd781, 10'd778, 10'd776, 10'd773, 10'd770, 10'd767, 10'd764, 10'd761, 10'd757,
		10'd754, 10'd750, 10'd746, 10'd742, 10'd738, 10'd733, 10'd729, 10'd724, 10'd720,
		10'd715, 10'd710, 10'd705, 10'd699, 10'd694, 10'd688, 10'd683, 10'd677, 10'd671,
		10'd665, 10'd658, 10'd652, 10'd646, 10'd639, 10'd632, 10'd625, 10'd618, 10'd611,
		10'd604, 10'd597, 10'd589, 10'd582, 10'd574, 10'd566, 10'd558, 10'd550, 10'd542,
		10'd534, 10'd526, 10'd517, 10'd509, 10'd500, 10'd491, 10'd482, 10'd474, 10'd465,
		10'd455, 10'd446, 10'd437, 10'd428, 10'd418, 10'd409, 10'd399, 10'd389, 10'd380,
		10'd370, 10'd360, 10'd350, 10'd340, 10'd330, 10'd319, 10'd309, 10'd299, 10'd289,
		10'd278, 10'd268, 10'd257, 10'd247, 10'd236, 10'd225, 10'd215, 10'd204, 10'd193,
		10'd182, 10'd171, 10'd160, 10'd150, 10'd139, 10'd128, 10'd117, 10'd106, 10'd94,
		10'd83, 10'd72, 10'd61, 10'd50, 10'd39, 10'd28, 10'd17, 10'd6
	};

	// modulation index, units of 0.0001
	localparam int M_FULL  = 10000;
	localparam int M_FLOOR = 10;
	localparam int M_RESET = 6250;

	// boost duty limits
	localparam int DUTY_MIN    = 2;
	localparam int DUTY_MARGIN = 5;

	// voltage regulator
	localparam logic signed [13:0] V_DEAD    = 14'sd2;
	localparam logic signed [13:0] V_LIM     = 14'sd20;
	localparam logic signed [5:0]  V_STEP_LO = 6'sd1;
	localparam logic signed [5:0]  V_STEP_HI = 6'sd3;

	// current regulator
	localparam logic signed [13:0] I_DEAD    = 14'sd10;
	localparam logic signed [13:0] I_LIM     = 14'sd50;
	localparam logic signed [5:0]  I_STEP_LO = 6'sd3;
	localparam logic signed [5:0]  I_STEP_HI = 6'sd15;

	// divide by M_FULL: exact reciprocal for a 24-bit magnitude
	localparam int SCALE_MAG_W   = 24;
	localparam int SCALE_SHIFT   = 38;
	localparam int SCALE_RECIP_W = 25;
	localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP =
		SCALE_RECIP_W'(((64'd1 << SCALE_SHIFT) + 64'(M_FULL) - 64'd1) / 64'(M_FULL));

	typedef enum logic [1:0] {
		REG_VOLTAGE_REF   = 2'd0,
		REG_CURRENT_REF   = 2'd1,
		REG_CARRIER_COUNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [13:0] modulation;
		logic [10:0] boost_compare;
		logic        updated;
	} reg_ctl_t;

	function automatic logic signed [5:0] step_toward(
		input logic signed [13:0] err,
		input logic signed [13:0] dead,
		input logic signed [13:0] lim,
		input logic signed [5:0]  step_lo,
		input logic signed [5:0]  step_hi
	);
		logic signed [5:0] res;
		res = '0;
		if (err > dead && err <= lim) begin
			res = -step_lo;
		end else if (err < -dead && err >= -lim) begin
			res = step_lo;
		end else if (err > lim) begin
			res = -step_hi;
		end else if (err < -lim) begin
			res = step_hi;
		end
		return res;
	endfunction

	// positive half, negated half, zero beyond
	function automatic logic signed [10:0] sine_entry(input logic [12:0] idx);
		logic [12:0] off;
		logic [10:0] mag;
		logic signed [10:0] res;
		off = idx - 13'(HALF_WAVE_LEN);
		mag = '0;
		res = '0;
		if (idx < 13'(HALF_WAVE_LEN)) begin
			mag = {1'b0, HALF_WAVE[idx[7:0]]};
			res = $signed(mag);
		end else if (idx < 13'(2 * HALF_WAVE_LEN)) begin
			mag = {1'b0, HALF_WAVE[off[7:0]]};
			res = -$signed(mag);
		end
		return res;
	endfunction

endpackage

// ===== sv/spwmsr_sine_rom.sv =====
// ----------------------------------------------------------------------------
// SPWM sine table
// Table memory loaded by a sweep after reset, with read-ahead of the next
// table position so the registered entry always matches the current one.
// ----------------------------------------------------------------------------
module spwmsr_sine_rom #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [9:0]               carrier_count,
	output logic                     ready,
	output logic signed [10:0]       entry
);

	localparam int PW = $clog2(TABLE_DEPTH);

	logic signed [10:0] mem [TABLE_DEPTH];
	logic [PW:0]        fill_q;
	logic [PW-1:0]      pos_q;
	logic [PW:0]        pos_inc;
	logic [PW-1:0]      pos_next;
	logic [PW-1:0]      rd_addr;
	logic               filling;
	logic               wrap;
	logic signed [10:0] entry_q;

	assign filling = (fill_q != (PW+1)'(TABLE_DEPTH));
	assign ready   = !filling;
	assign entry   = entry_q;

	assign pos_inc  = {1'b0, pos_q} + (PW+1)'(1);
	assign wrap     = (32'(pos_inc) >= 32'(carrier_count)) ||
	                  (pos_inc >= (PW+1)'(TABLE_DEPTH));
	assign pos_next = wrap ? '0 : pos_inc[PW-1:0];
	assign rd_addr  = accept ? pos_next : pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
		end else begin
			if (filling) begin
				fill_q <= fill_q + (PW+1)'(1);
			end
			if (accept) begin
				pos_q <= pos_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (filling) begin
			mem[fill_q[PW-1:0]] <= spwmsr_pkg::sine_entry(13'(fill_q));
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= mem[rd_addr];
	end

endmodule

// ===== sv/spwmsr_regulator.sv =====
// ----------------------------------------------------------------------------
// SPWM regulators
// Window totals, averaging and the two step regulators for modulation index
// and boost duty. Presents the values that apply to the word being taken.
// ----------------------------------------------------------------------------
module spwmsr_regulator #(
	parameter int AVERAGE_WINDOW = 50,
	parameter int PWM_PERIOD     = 1600
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [11:0]           voltage_sample,
	input  logic [11:0]           current_sample,
	input  logic [11:0]           voltage_reference,
	input  logic [11:0]           current_reference,
	output spwmsr_pkg::reg_ctl_t  ctl
);

	localparam int LW    = $clog2(AVERAGE_WINDOW);
	localparam int TW    = LW + 12;
	localparam int CNW   = (LW > 0) ? LW : 1;
	localparam int SHIFT = TW + LW;
	localparam int RW    = TW + 1;
	localparam int PRW   = TW + RW;
	localparam longint unsigned RECIP_L =
		((64'd1 << SHIFT) + 64'(AVERAGE_WINDOW) - 64'd1) / 64'(AVERAGE_WINDOW);
	localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
	localparam int DW  = $clog2(PWM_PERIOD);
	localparam int DSW = DW + 2;

	logic [TW-1:0]  vt_q, ct_q;
	logic [CNW-1:0] cnt_q;
	logic [13:0]    m_q;
	logic [DW-1:0]  duty_q;
	logic [10:0]    bc_q;

	logic [TW-1:0]         vsum, csum;
	logic [PRW-1:0]        vprod, cprod;
	logic [11:0]           vavg, cavg;
	logic signed [13:0]    verr, cerr;
	logic signed [5:0]     vstep, cstep;
	logic signed [15:0]    msum;
	logic signed [DSW-1:0] dsum;
	logic [13:0]           m_new;
	logic [DW-1:0]         duty_new;
	logic [10:0]           bc_new;
	logic                  close;

	always_comb begin
		vsum  = vt_q + TW'(voltage_sample);
		csum  = ct_q + TW'(current_sample);
		close = (cnt_q == CNW'(AVERAGE_WINDOW - 1));

		// average by reciprocal multiply, exact over the total's range
		vprod = PRW'(vsum) * PRW'(RECIP);
		cprod = PRW'(csum) * PRW'(RECIP);
		vavg  = vprod[SHIFT+11:SHIFT];
		cavg  = cprod[SHIFT+11:SHIFT];

		verr  = $signed({2'b00, vavg}) - $signed({2'b00, voltage_reference});
		cerr  = $signed({2'b00, cavg}) - $signed({2'b00, current_reference});
		vstep = spwmsr_pkg::step_toward(verr, spwmsr_pkg::V_DEAD, spwmsr_pkg::V_LIM,
			spwmsr_pkg::V_STEP_LO, spwmsr_pkg::V_STEP_HI);
		cstep = spwmsr_pkg::step_toward(cerr, spwmsr_pkg::I_DEAD, spwmsr_pkg::I_LIM,
			spwmsr_pkg::I_STEP_LO, spwmsr_pkg::I_STEP_HI);

		msum = $signed({2'b00, m_q}) + 16'(vstep);
		if (msum > $signed(16'(spwmsr_pkg::M_FULL))) begin
			m_new = 14'(spwmsr_pkg::M_FULL);
		end else if (msum <= $signed(16'(0))) begin
			m_new = 14'(spwmsr_pkg::M_FLOOR);
		end else begin
			m_new = msum[13:0];
		end

		// positive current error lowers the duty
		dsum = $signed({2'b00, duty_q}) + DSW'(cstep);
		if (dsum < $signed(DSW'(spwmsr_pkg::DUTY_MIN))) begin
			duty_new = DW'(spwmsr_pkg::DUTY_MIN);
		end else if (dsum > $signed(DSW'(PWM_PERIOD - spwmsr_pkg::DUTY_MARGIN))) begin
			duty_new = DW'(PWM_PERIOD - spwmsr_pkg::DUTY_MARGIN);
		end else begin
			duty_new = dsum[DW-1:0];
		end
		bc_new = 11'(PWM_PERIOD - 32'(duty_new));

		ctl.updated       = close;
		ctl.modulation    = close ? m_new : m_q;
		ctl.boost_compare = close ? bc_new : bc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vt_q   <= '0;
			ct_q   <= '0;
			cnt_q  <= '0;
			m_q    <= 14'(spwmsr_pkg::M_RESET);
			duty_q <= DW'(PWM_PERIOD / 2);
			bc_q   <= 11'(PWM_PERIOD - PWM_PERIOD / 2);
		end else if (accept) begin
			if (close) begin
				vt_q   <= '0;
				ct_q   <= '0;
				cnt_q  <= '0;
				m_q    <= m_new;
				duty_q <= duty_new;
				bc_q   <= bc_new;
			end else begin
				vt_q  <= vsum;
				ct_q  <= csum;
				cnt_q <= cnt_q + CNW'(1);
			end
		end
	end

endmodule

// ===== sv/spwmsr_scale.sv =====
// ----------------------------------------------------------------------------
// SPWM compare scaling
// Three-stage pipeline: capture, index times table entry, divide by full
// scale and offset by half period. Each stage stalls only when full.
// ----------------------------------------------------------------------------
module spwmsr_scale #(
	parameter int PWM_PERIOD = 1600
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [10:0]    entry,
	input  spwmsr_pkg::reg_ctl_t  ctl,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [10:0]           spwm_compare,
	output spwmsr_pkg::reg_ctl_t  out_ctl
);

	localparam int PRODW = 26;
	localparam int QW    = spwmsr_pkg::SCALE_MAG_W + spwmsr_pkg::SCALE_RECIP_W;

	logic v1_s1, v2_s2, v3_s3;
	logic rdy1, rdy2, rdy3;

	logic signed [10:0]   entry_s1;
	spwmsr_pkg::reg_ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic signed [PRODW-1:0] prod_s2;
	logic [10:0]          spwm_s3;

	logic signed [14:0]      mod_sx;
	logic signed [PRODW-1:0] prod_d;
	logic                    neg;
	logic signed [PRODW-1:0] mag_full;
	logic [spwmsr_pkg::SCALE_MAG_W-1:0] mag;
	logic [QW-1:0]           qprod;
	logic [10:0]             quot;
	logic [10:0]             half;
	logic [10:0]             spwm_d;

	assign rdy3     = !v3_s3 || out_ready;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		mod_sx = $signed({1'b0, ctl_s1.modulation});
		prod_d = PRODW'(mod_sx) * PRODW'(entry_s1);
	end

	// truncation toward zero: divide the magnitude, then restore the sign
	always_comb begin
		neg      = prod_s2[PRODW-1];
		mag_full = neg ? -prod_s2 : prod_s2;
		mag      = mag_full[spwmsr_pkg::SCALE_MAG_W-1:0];
		qprod    = QW'(mag) * QW'(spwmsr_pkg::SCALE_RECIP);
		quot     = qprod[QW-1:spwmsr_pkg::SCALE_SHIFT];
		half     = 11'(PWM_PERIOD / 2);
		spwm_d   = neg ? (half - quot) : (half + quot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_s1 <= in_valid;
			end
			if (rdy2) begin
				v2_s2 <= v1_s1;
			end
			if (rdy3) begin
				v3_s3 <= v2_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			entry_s1 <= entry;
			ctl_s1   <= ctl;
		end
		if (rdy2 && v1_s1) begin
			prod_s2 <= prod_d;
			ctl_s2  <= ctl_s1;
		end
		if (rdy3 && v2_s2) begin
			spwm_s3 <= spwm_d;
			ctl_s3  <= ctl_s2;
		end
	end

	assign out_valid    = v3_s3;
	assign spwm_compare = spwm_s3;
	assign out_ctl      = ctl_s3;

endmodule

// ===== sv/spwm_generator_with_step_regulators.sv =====
// A result word is registered in the capture, product and divide stages; a stall can
// hold it. Throughput: one word per cycle while s_axis_tready is high; the regulator
// state is read and updated in the accepting cycle and the sine table entry is read
// ahead. Reset: control state resets at once; then all TABLE_DEPTH (512 by default)
// sine table entries are loaded with s_axis_tready low; cfg writes are taken.
// ----------------------------------------------------------------------------
// SPWM generator with step regulators
// Sine-table inverter compare values scaled by a regulated modulation index,
// plus a window-averaged step regulator for the boost compare value.
// ----------------------------------------------------------------------------
module spwm_generator_with_step_regulators #(
	parameter int TABLE_DEPTH    = 512,
	parameter int AVERAGE_WINDOW = 50,
	parameter int PWM_PERIOD     = 1600
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // voltage_sample[11:0], current_sample[23:12]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // spwm_compare[10:0], boost_compare[21:11],
	                                    // modulation_now[35:22], zero[39:36]
	output logic        m_axis_tuser,   // boost_updated
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [11:0] cfg_wdata
);

	logic [11:0] vref_q;
	logic [11:0] iref_q;
	logic [9:0]  carrier_q;

	logic                 accept;
	logic                 rom_ready;
	logic                 scale_ready;
	logic signed [10:0]   entry;
	spwmsr_pkg::reg_ctl_t ctl;
	spwmsr_pkg::reg_ctl_t out_ctl;
	logic [10:0]          spwm_compare;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vref_q    <= 12'd1193;
			iref_q    <= 12'd496;
			carrier_q <= 10'd450;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				spwmsr_pkg::REG_VOLTAGE_REF:   vref_q    <= cfg_wdata;
				spwmsr_pkg::REG_CURRENT_REF:   iref_q    <= cfg_wdata;
				spwmsr_pkg::REG_CARRIER_COUNT: carrier_q <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = rom_ready && scale_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	spwmsr_sine_rom #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_rom (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.carrier_count(carrier_q),
		.ready        (rom_ready),
		.entry        (entry)
	);

	spwmsr_regulator #(
		.AVERAGE_WINDOW(AVERAGE_WINDOW),
		.PWM_PERIOD    (PWM_PERIOD)
	) u_reg (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.voltage_sample   (s_axis_tdata[11:0]),
		.current_sample   (s_axis_tdata[23:12]),
		.voltage_reference(vref_q),
		.current_reference(iref_q),
		.ctl              (ctl)
	);

	spwmsr_scale #(
		.PWM_PERIOD(PWM_PERIOD)
	) u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid && rom_ready),
		.in_ready    (scale_ready),
		.entry       (entry),
		.ctl         (ctl),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.spwm_compare(spwm_compare),
		.out_ctl     (out_ctl)
	);

	assign m_axis_tdata = {4'b0000, out_ctl.modulation, out_ctl.boost_compare, spwm_compare};
	assign m_axis_tuser = out_ctl.updated;

endmodule

// ===== sv/spwmsr_checker.sv =====
// ----------------------------------------------------------------------------
// SPWM generator checker
// Port-level properties of the generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "spwm_generator_with_step_regulators_macros.svh"

module spwmsr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	logic        out_hs;
	logic        have_q;
	logic [10:0] last_bc_q;
	logic [13:0] last_m_q;

	assign out_hs = m_axis_tvalid && m_axis_tready;

	// last delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q    <= 1'b0;
			last_bc_q <= '0;
			last_m_q  <= '0;
		end else if (out_hs) begin
			have_q    <= 1'b1;
			last_bc_q <= m_axis_tdata[21:11];
			last_m_q  <= m_axis_tdata[35:22];
		end
	end

	`SPWMSR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")
	`SPWMSR_ASSERT(a_regs_held, out_hs && have_q && !m_axis_tuser |-> m_axis_tdata[21:11] == last_bc_q && m_axis_tdata[35:22] == last_m_q, "regulator outputs moved without window close")
	`SPWMSR_ASSERT(a_mod_step, out_hs && have_q && m_axis_tuser |-> (15'(m_axis_tdata[35:22]) <= 15'(last_m_q) + 15'd3) && (15'(last_m_q) <= 15'(m_axis_tdata[35:22]) + 15'd3), "modulation index stepped too far")
	// reset alone settles the handshake outputs
	`SPWMSR_ASSERT_RST(a_reset_quiet, !arst_n |=> !m_axis_tvalid && !s_axis_tready, "handshake active during reset")

endmodule

bind spwm_generator_with_step_regulators spwmsr_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

// ===== test/spwm_generator_with_step_regulators_tb.sv =====
// ----------------------------------------------------------------------------
// SPWM generator with step regulators - testbench
// Streams voltage/current sample words into the block and checks every output
// word against a cycle-free predictor of the averaging window, both step
// regulators and the scaled sine lookup. Runs directed corner words and carrier
// register cases, then windowed random stimulus under three reference/carrier
// settings and three back-pressure mixes.
// ----------------------------------------------------------------------------
module spwm_generator_with_step_regulators_tb;

	localparam int TABLE_DEPTH    = 512;
	localparam int AVERAGE_WINDOW = 50;
	localparam int PWM_PERIOD     = 1600;
	localparam int SAMPLE_MAX     = 4095;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int TAIL_CYCLES    = 20;
	localparam int PHASE_WORDS    = 644;

	// spare register slot: writes there must change nothing
	localparam logic [1:0] REG_SPARE = 2'd3;

	// regulator bands
	localparam int V_DEADBAND = 2;
	localparam int V_EDGE     = 20;
	localparam int V_FINE     = 1;
	localparam int V_COARSE   = 3;
	localparam int I_DEADBAND = 10;
	localparam int I_EDGE     = 50;
	localparam int I_FINE     = 3;
	localparam int I_COARSE   = 15;

	typedef struct packed {
		logic [11:0] voltage;
		logic [11:0] current;
	} sample_word_t;

	typedef struct packed {
		logic [10:0] spwm;
		logic [10:0] boost;
		logic        updated;
		logic [13:0] modulation;
	} compare_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // voltage_sample[11:0], current_sample[23:12]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // spwm_compare[10:0], boost_compare[21:11],
	                                  // modulation_now[35:22], zero[39:36]
	logic        m_axis_tuser;        // boost_updated
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [11:0] cfg_wdata = '0;

	spwm_generator_with_step_regulators u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	int sine_lut [TABLE_DEPTH];
	int volt_ref = 1193;
	int curr_ref = 496;
	int carrier = 450;
	int table_pos = 0;
	int window_fill = 0;
	int volt_total = 0;
	int curr_total = 0;
	int mod_index = spwmsr_pkg::M_RESET;
	int boost_duty = PWM_PERIOD / 2;
	int boost_hold = PWM_PERIOD / 2;

	sample_word_t  samples_pending [$];
	compare_word_t words_due [$];
	int queued_words = 0;
	int accepted_words = 0;
	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	function automatic int regulator_step(input int err, input int dead, input int edge_lim,
			input int fine, input int coarse);
		int mag;
		int delta;
		mag = (err < 0) ? -err : err;
		if (mag <= dead)
			delta = 0;
		else if (mag <= edge_lim)
			delta = fine;
		else
			delta = coarse;
		return (err > 0) ? -delta : delta;
	endfunction

	task automatic predict_compare_word(input logic [11:0] v, input logic [11:0] c);
		int vavg;
		int cavg;
		int entry;
		int spwm;
		compare_word_t w;
		w.updated = 1'b0;
		volt_total += v;
		curr_total += c;
		window_fill++;
		if (window_fill >= AVERAGE_WINDOW) begin
			vavg = volt_total / AVERAGE_WINDOW;
			cavg = curr_total / AVERAGE_WINDOW;
			volt_total = 0;
			curr_total = 0;
			window_fill = 0;
			w.updated = 1'b1;
			mod_index += regulator_step(vavg - volt_ref, V_DEADBAND, V_EDGE, V_FINE, V_COARSE);
			if (mod_index > spwmsr_pkg::M_FULL)
				mod_index = spwmsr_pkg::M_FULL;
			if (mod_index <= 0)
				mod_index = spwmsr_pkg::M_FLOOR;
			boost_duty += regulator_step(cavg - curr_ref, I_DEADBAND, I_EDGE, I_FINE, I_COARSE);
			if (boost_duty < spwmsr_pkg::DUTY_MIN)
				boost_duty = spwmsr_pkg::DUTY_MIN;
			if (boost_duty > PWM_PERIOD - spwmsr_pkg::DUTY_MARGIN)
				boost_duty = PWM_PERIOD - spwmsr_pkg::DUTY_MARGIN;
			boost_hold = PWM_PERIOD - boost_duty;
		end
		entry = sine_lut[table_pos];
		// signed division truncates toward zero
		spwm = (mod_index * entry) / spwmsr_pkg::M_FULL + PWM_PERIOD / 2;
		table_pos++;
		if (table_pos >= carrier || table_pos >= TABLE_DEPTH)
			table_pos = 0;
		w.spwm = 11'(spwm);
		w.boost = 11'(boost_hold);
		w.modulation = 14'(mod_index);
		words_due.push_back(w);
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (samples_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_axis_tdata <= {samples_pending[0].current, samples_pending[0].voltage};
				s_axis_tvalid <= 1'b1;
				void'(samples_pending.pop_front());
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// monitor: check the result first so a word taken this edge cannot match it
	always @(posedge clk) begin
		compare_word_t got;
		compare_word_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.spwm = m_axis_tdata[10:0];
				got.boost = m_axis_tdata[21:11];
				got.modulation = m_axis_tdata[35:22];
				got.updated = m_axis_tuser;
				if (words_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected word: spwm %0d boost %0d upd %0b mod %0d",
							got.spwm, got.boost, got.updated, got.modulation);
					mismatches++;
				end else begin
					want = words_due.pop_front();
					if (got.spwm !== want.spwm || got.boost !== want.boost
							|| got.updated !== want.updated
							|| got.modulation !== want.modulation) begin
						if (mismatches < 10)
							$display("mismatch: exp spwm %0d boost %0d upd %0b mod %0d, %s",
								want.spwm, want.boost, want.updated, want.modulation,
								$sformatf("got spwm %0d boost %0d upd %0b mod %0d",
								got.spwm, got.boost, got.updated, got.modulation));
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_compare_word(s_axis_tdata[11:0], s_axis_tdata[23:12]);
				accepted_words++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic queue_word(input int v, input int c);
		sample_word_t s;
		s.voltage = 12'(v);
		s.current = 12'(c);
		samples_pending.push_back(s);
		queued_words++;
	endtask

	task automatic wait_drained();
		while (accepted_words != queued_words || words_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] addr, input logic [11:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (addr)
			spwmsr_pkg::REG_VOLTAGE_REF:   volt_ref = data;
			spwmsr_pkg::REG_CURRENT_REF:   curr_ref = data;
			spwmsr_pkg::REG_CARRIER_COUNT: carrier = data[9:0];
			default: ;
		endcase
	endtask

	function automatic int clamp_sample(input int x);
		if (x < 0)
			return 0;
		if (x > SAMPLE_MAX)
			return SAMPLE_MAX;
		return x;
	endfunction

	// error offsets aimed at the band edges of a regulator
	function automatic int band_offset(input int dead, input int edge_lim);
		int mag;
		case ($urandom_range(0, 5))
			0: mag = 0;
			1: mag = dead;
			2: mag = dead + 1;
			3: mag = edge_lim;
			4: mag = edge_lim + 1;
			default: mag = int'($urandom_range(edge_lim + 2, 900));
		endcase
		return $urandom_range(0, 1) ? mag : -mag;
	endfunction

	// new shape at window start and call: flat (exact average), jittered, or noise
	task automatic queue_windowed_words(input int count);
		int shape;
		int v_target;
		int c_target;
		int spread;
		int v;
		int c;
		for (int n = 0; n < count; n++) begin
			if (n == 0 || queued_words % AVERAGE_WINDOW == 0) begin
				shape = $urandom_range(0, 19);
				v_target = clamp_sample(volt_ref + band_offset(V_DEADBAND, V_EDGE));
				c_target = clamp_sample(curr_ref + band_offset(I_DEADBAND, I_EDGE));
				spread = $urandom_range(1, 40);
			end
			if (shape < 11) begin
				v = v_target;
				c = c_target;
			end else if (shape < 17) begin
				v = clamp_sample(v_target + int'($urandom_range(0, 2 * spread)) - spread);
				c = clamp_sample(c_target + int'($urandom_range(0, 2 * spread)) - spread);
			end else begin
				v = $urandom_range(0, SAMPLE_MAX);
				c = $urandom_range(0, SAMPLE_MAX);
			end
			queue_word(v, c);
		end
	endtask

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (i < spwmsr_pkg::HALF_WAVE_LEN)
				sine_lut[i] = int'(spwmsr_pkg::HALF_WAVE[i]);
			else if (i < 2 * spwmsr_pkg::HALF_WAVE_LEN)
				sine_lut[i] = -int'(spwmsr_pkg::HALF_WAVE[i - spwmsr_pkg::HALF_WAVE_LEN]);
			else
				sine_lut[i] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes at reset settings
		send_idle_pct = 17;
		recv_idle_pct = 72;
		queue_word(0, 0);
		queue_word(SAMPLE_MAX, SAMPLE_MAX);
		queue_word(0, SAMPLE_MAX);
		queue_word(SAMPLE_MAX, 0);
		queue_word(12'hAAA, 12'h555);
		queue_word(12'h555, 12'hAAA);
		queue_word(1, 2048);
		queue_word(2048, 1);
		wait_drained();

		// zero carrier count: entry 0 for every word after the first
		write_reg(spwmsr_pkg::REG_CARRIER_COUNT, 12'h000);
		repeat (5)
			queue_word($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
		wait_drained();

		// upper data bits are dropped, leaving a count of one
		write_reg(spwmsr_pkg::REG_CARRIER_COUNT, 12'hC01);
		repeat (5)
			queue_word($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
		wait_drained();
		write_reg(REG_SPARE, 12'hFFF);
		repeat (4)
			queue_word($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
		wait_drained();

		// count past the table: wraps at the table depth
		write_reg(spwmsr_pkg::REG_VOLTAGE_REF, 12'hFFF);
		write_reg(spwmsr_pkg::REG_CURRENT_REF, 12'h000);
		write_reg(spwmsr_pkg::REG_CARRIER_COUNT, 12'h3FF);
		queue_windowed_words(PHASE_WORDS);
		wait_drained();

		send_idle_pct = 72;
		recv_idle_pct = 17;
		write_reg(spwmsr_pkg::REG_VOLTAGE_REF, 12'h000);
		write_reg(spwmsr_pkg::REG_CURRENT_REF, 12'hFFF);
		write_reg(spwmsr_pkg::REG_CARRIER_COUNT, 12'h200);
		queue_windowed_words(PHASE_WORDS);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(spwmsr_pkg::REG_VOLTAGE_REF, 12'($urandom_range(100, 3995)));
		write_reg(spwmsr_pkg::REG_CURRENT_REF, 12'($urandom_range(100, 3995)));
		write_reg(spwmsr_pkg::REG_CARRIER_COUNT, 12'($urandom_range(1, TABLE_DEPTH)));
		queue_windowed_words(PHASE_WORDS / 2);
		// sender holds off until the block has emptied
		wait_drained();
		queue_windowed_words(PHASE_WORDS - PHASE_WORDS / 2);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && words_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/spwmsr_pkg.sv
sv/spwmsr_sine_rom.sv
sv/spwmsr_regulator.sv
sv/spwmsr_scale.sv
sv/spwm_generator_with_step_regulators.sv
sv/spwmsr_checker.sv
test/spwm_generator_with_step_regulators_tb.sv
